### rtl/frqg_pkg.sv
// ----------------------------------------------------------------------------
// Frame rate quality governor package
// Shared widths, reset values, register indexes and level codes.
// ----------------------------------------------------------------------------
package frqg_pkg;

  localparam int FRAME_W    = 20;
  localparam int INTERVAL_W = 24;
  localparam int THRESH_W   = 20;
  localparam int WSIZE_W    = 7;
  localparam int LEVEL_W    = 2;
  localparam int OSUM_W     = 26;
  localparam int OCOUNT_W   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int MAX_WINDOW_DEF = 64;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 24'd1000000;
  localparam logic [THRESH_W-1:0]   SLOW_RST     = 20'd33333;
  localparam logic [THRESH_W-1:0]   FAST_RST     = 20'd14285;
  localparam logic                  AUTO_RST     = 1'b1;
  localparam logic [WSIZE_W-1:0]    WSIZE_RST    = 7'd60;

  localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_ULTRA = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPDATE_INTERVAL = 3'd0,
    CFG_SLOW_FRAME      = 3'd1,
    CFG_FAST_FRAME      = 3'd2,
    CFG_AUTO_ADJUST     = 3'd3,
    CFG_WINDOW_SIZE     = 3'd4
  } cfg_reg_e;

endpackage

### rtl/frame_rate_quality_governor_unit.sv
// ----------------------------------------------------------------------------
// Frame rate quality governor
// Sliding-window frame time average with a four-step quality level.
// ----------------------------------------------------------------------------
// Each input word on the frame channel (in_valid_i / in_stall_o) carries the
// duration of one finished frame in microseconds. Every word produces exactly
// one output word on the result channel (out_valid_o / out_stall_i) with the
// quality level, whether it changed, whether the interval elapsed, and the
// current window sum and count.
// The window lives in a ring memory of MAX_WINDOW entries. A word is written
// to the ring and the oldest entry is read in the cycle it is accepted; as
// the word leaves the second stage, the running sum, the elapsed time and the
// level are adjusted and the output register is loaded. One word is accepted
// per cycle while in_stall_o is low; the rate is set by the single ring read
// per word, which is pipelined ahead of the sum update.
// When the receiver stalls, the output register and then the internal stage
// fill; in_stall_o rises only when both are full and the output is stalled.
// Reset clears the level, sums, count, head and elapsed time and loads the
// register defaults; the ring contents need no clearing since only written
// entries are ever read.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken.
// ----------------------------------------------------------------------------
module frame_rate_quality_governor_unit #(
  parameter int MAX_WINDOW = frqg_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [frqg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [frqg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [frqg_pkg::FRAME_W-1:0]    frame_us_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [frqg_pkg::LEVEL_W-1:0]    level_o,
  output logic                           level_changed_o,
  output logic                           evaluated_o,
  output logic [frqg_pkg::OSUM_W-1:0]     window_sum_o,
  output logic [frqg_pkg::OCOUNT_W-1:0]   window_count_o
);

  localparam int FRAME_W = frqg_pkg::FRAME_W;
  localparam int ELAP_W  = frqg_pkg::INTERVAL_W;
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W  = $clog2(MAX_WINDOW);
  localparam int SUM_W   = FRAME_W + CNT_W;
  localparam int PROD_W  = frqg_pkg::THRESH_W + CNT_W;
  localparam int CMP_W   = (CNT_W > frqg_pkg::WSIZE_W) ? CNT_W : frqg_pkg::WSIZE_W;

  // Configuration registers.
  logic [ELAP_W-1:0]                 interval_q;
  logic [frqg_pkg::THRESH_W-1:0]     slow_q;
  logic [frqg_pkg::THRESH_W-1:0]     fast_q;
  logic                              auto_q;
  logic [frqg_pkg::WSIZE_W-1:0]      wsize_q;

  // Window control, updated at acceptance.
  logic [ADDR_W-1:0]                 head_q, head_d;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [ADDR_W-1:0]                 rd_addr;
  logic                              drop;
  logic                              add_new;

  // Ring memory and its read data.
  logic [FRAME_W-1:0]                hist_mem [MAX_WINDOW];
  logic [FRAME_W-1:0]                rd_q;

  // Second stage.
  logic                              s1_valid_q;
  logic [FRAME_W-1:0]                s1_frame_q;
  logic                              s1_drop_q;
  logic                              s1_add_q;
  logic [CNT_W-1:0]                  s1_count_q;
  logic [PROD_W-1:0]                 s1_slow_q, s1_fast_q;

  // Accumulated state, updated as a word leaves the second stage.
  logic [SUM_W-1:0]                  sum_q, sum_d;
  logic [ELAP_W-1:0]                 elapsed_q, elapsed_d;
  logic [frqg_pkg::LEVEL_W-1:0]      level_q, level_d;
  logic                              changed_d, eval_d;
  logic [ELAP_W:0]                   elap_sum;
  logic [ELAP_W-1:0]                 elap_sat;

  // Output register.
  logic                              out_valid_q;
  logic                              out_changed_q, out_eval_q;
  logic [SUM_W-1:0]                  out_sum_q;
  logic [CNT_W-1:0]                  out_count_q;
  logic [frqg_pkg::LEVEL_W-1:0]      out_level_q;

  logic                              accept, adv1, s1_free;
  logic [CMP_W-1:0]                  eff, wsize_ext, max_ext, before_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= frqg_pkg::INTERVAL_RST;
      slow_q     <= frqg_pkg::SLOW_RST;
      fast_q     <= frqg_pkg::FAST_RST;
      auto_q     <= frqg_pkg::AUTO_RST;
      wsize_q    <= frqg_pkg::WSIZE_RST;
    end else if (cfg_valid_i) begin
      unique case (frqg_pkg::cfg_reg_e'(cfg_index_i))
        frqg_pkg::CFG_UPDATE_INTERVAL: interval_q <= cfg_data_i[ELAP_W-1:0];
        frqg_pkg::CFG_SLOW_FRAME:      slow_q     <= cfg_data_i[frqg_pkg::THRESH_W-1:0];
        frqg_pkg::CFG_FAST_FRAME:      fast_q     <= cfg_data_i[frqg_pkg::THRESH_W-1:0];
        frqg_pkg::CFG_AUTO_ADJUST:     auto_q     <= cfg_data_i[0];
        frqg_pkg::CFG_WINDOW_SIZE:     wsize_q    <= cfg_data_i[frqg_pkg::WSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow.
  assign adv1       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_free    = !s1_valid_q || adv1;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  // Effective window size, count after this word, and the oldest slot.
  always_comb begin
    wsize_ext  = CMP_W'(wsize_q);
    max_ext    = CMP_W'(MAX_WINDOW);
    before_ext = CMP_W'(count_q);
    eff        = (wsize_ext > max_ext) ? max_ext : wsize_ext;
    if (before_ext < eff) begin
      count_d = count_q + CNT_W'(1);
      drop    = 1'b0;
      add_new = 1'b1;
    end else begin
      // Window full: the new word replaces the oldest one. An empty window
      // of size zero takes the word and lets it go again at once.
      count_d = count_q;
      drop    = (count_q != '0);
      add_new = drop;
    end
    if (CNT_W'(head_q) >= count_q) begin
      rd_addr = head_q - ADDR_W'(count_q);
    end else begin
      rd_addr = ADDR_W'(CNT_W'(MAX_WINDOW) - (count_q - CNT_W'(head_q)));
    end
    head_d = (head_q == ADDR_W'(MAX_WINDOW - 1)) ? '0 : head_q + ADDR_W'(1);
  end

  // The read returns the old contents when it hits the slot being written.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_mem[head_q] <= frame_us_i;
      rd_q             <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_frame_q <= frame_us_i;
      s1_drop_q  <= drop;
      s1_add_q   <= add_new;
      s1_count_q <= count_d;
      s1_slow_q  <= PROD_W'(count_d) * PROD_W'(slow_q);
      s1_fast_q  <= PROD_W'(count_d) * PROD_W'(fast_q);
    end
  end

  // Sum, elapsed time and level update.
  always_comb begin
    sum_d     = sum_q + (s1_add_q ? SUM_W'(s1_frame_q) : '0)
                - (s1_drop_q ? SUM_W'(rd_q) : '0);
    elap_sum  = {1'b0, elapsed_q} + (ELAP_W + 1)'(s1_frame_q);
    elap_sat  = elap_sum[ELAP_W] ? {ELAP_W{1'b1}} : elap_sum[ELAP_W-1:0];
    elapsed_d = elap_sat;
    level_d   = level_q;
    changed_d = 1'b0;
    eval_d    = 1'b0;
    if (elap_sat >= interval_q) begin
      eval_d    = 1'b1;
      elapsed_d = '0;
      if (auto_q) begin
        // An empty or all-zero window counts as too slow.
        if ((sum_d == '0) || (PROD_W'(sum_d) > s1_slow_q)) begin
          if (level_q != frqg_pkg::LEVEL_LOW) begin
            level_d   = level_q - frqg_pkg::LEVEL_W'(1);
            changed_d = 1'b1;
          end
        end else if (PROD_W'(sum_d) < s1_fast_q) begin
          if (level_q != frqg_pkg::LEVEL_ULTRA) begin
            level_d   = level_q + frqg_pkg::LEVEL_W'(1);
            changed_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      elapsed_q   <= '0;
      level_q     <= frqg_pkg::LEVEL_LOW;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        sum_q     <= sum_d;
        elapsed_q <= elapsed_d;
        level_q   <= level_d;
      end
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= adv1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      out_level_q   <= level_d;
      out_changed_q <= changed_d;
      out_eval_q    <= eval_d;
      out_sum_q     <= sum_d;
      out_count_q   <= s1_count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign level_o         = out_level_q;
  assign level_changed_o = out_changed_q;
  assign evaluated_o     = out_eval_q;
  assign window_sum_o    = frqg_pkg::OSUM_W'(out_sum_q);
  assign window_count_o  = frqg_pkg::OCOUNT_W'(out_count_q);

  // The ring never holds more entries than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_WINDOW))
    else $error("window count exceeds ring depth");

  // Input stalls only when both stages hold words and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // A level change is always reported together with an evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_changed_q) |-> out_eval_q)
    else $error("level change without evaluation");

  // The level only moves when a word leaves with the change flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(level_q) |-> (out_valid_q && out_changed_q && (out_level_q == level_q)))
    else $error("level moved without a reported change");

endmodule

### bench/tb_frame_rate_quality_governor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate quality governor testbench
// Sends frame times with random gaps and output stalls. A behavioral model
// of the ring, running sum, elapsed-time accumulator and level logic
// predicts every result word, and the words are checked in order.
// ----------------------------------------------------------------------------
module tb_frame_rate_quality_governor_unit;

  localparam int FRAME_W    = frqg_pkg::FRAME_W;
  localparam int INTERVAL_W = frqg_pkg::INTERVAL_W;
  localparam int THRESH_W   = frqg_pkg::THRESH_W;
  localparam int WSIZE_W    = frqg_pkg::WSIZE_W;
  localparam int LEVEL_W    = frqg_pkg::LEVEL_W;
  localparam int OSUM_W     = frqg_pkg::OSUM_W;
  localparam int OCOUNT_W   = frqg_pkg::OCOUNT_W;
  localparam int CFG_IDX_W  = frqg_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = frqg_pkg::CFG_DATA_W;

  localparam int RING_DEPTH = frqg_pkg::MAX_WINDOW_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ELAPSED_CAP = 24'hFFFFFF;
  localparam logic [FRAME_W-1:0] FRAME_MAX = 20'd1000000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 24'd10000000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_FRAMES = 50;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic                changed;
    logic                evaluated;
    logic [OSUM_W-1:0]   sum;
    logic [OCOUNT_W-1:0] count;
  } gov_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = frqg_pkg::CFG_UPDATE_INTERVAL;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [FRAME_W-1:0]    frame_us_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [LEVEL_W-1:0]    level_o;
  logic                  level_changed_o;
  logic                  evaluated_o;
  logic [OSUM_W-1:0]     window_sum_o;
  logic [OCOUNT_W-1:0]   window_count_o;

  frame_rate_quality_governor_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_us_i     (frame_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .level_o        (level_o),
    .level_changed_o(level_changed_o),
    .evaluated_o    (evaluated_o),
    .window_sum_o   (window_sum_o),
    .window_count_o (window_count_o)
  );

  // Model copy of the registers and the window state.
  logic [INTERVAL_W-1:0] m_interval;
  logic [THRESH_W-1:0]   m_slow;
  logic [THRESH_W-1:0]   m_fast;
  logic                  m_auto;
  logic [WSIZE_W-1:0]    m_wsize;
  logic [FRAME_W-1:0]    m_ring [RING_DEPTH];
  int unsigned           m_head;
  int unsigned           m_count;
  int unsigned           m_elapsed;
  longint unsigned       m_sum;
  logic [LEVEL_W-1:0]    m_level;

  gov_report_t expected_reports[$];
  gov_report_t seen_report;
  gov_report_t want_report;
  int          errors = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic gov_report_t governor_step(input logic [FRAME_W-1:0] f);
    int unsigned     eff;
    int unsigned     slot;
    int unsigned     held;
    int unsigned     oldest;
    int unsigned     acc;
    longint unsigned slow_lim;
    longint unsigned fast_lim;
    gov_report_t     r;
    eff = (m_wsize > RING_DEPTH) ? RING_DEPTH : m_wsize;
    slot = m_head % RING_DEPTH;
    held = (m_count > RING_DEPTH) ? RING_DEPTH : m_count;
    oldest = f;
    // With a full ring the oldest entry sits in the slot about to be written.
    if (held > 0) oldest = m_ring[(slot + RING_DEPTH - held) % RING_DEPTH];
    m_ring[slot] = f;
    m_head = (slot + 1) % RING_DEPTH;
    m_sum += f;
    m_count = held + 1;
    if (m_count > eff) begin
      m_sum -= oldest;
      m_count--;
    end
    acc = m_elapsed + f;
    m_elapsed = (acc > ELAPSED_CAP) ? ELAPSED_CAP : acc;
    r.changed = 1'b0;
    r.evaluated = 1'b0;
    if (m_elapsed >= m_interval) begin
      r.evaluated = 1'b1;
      m_elapsed = 0;
      if (m_auto) begin
        slow_lim = m_count;
        slow_lim = slow_lim * m_slow;
        fast_lim = m_count;
        fast_lim = fast_lim * m_fast;
        // An empty or all-zero window counts as too slow.
        if (m_sum == 0 || m_sum > slow_lim) begin
          if (m_level != frqg_pkg::LEVEL_LOW) begin
            m_level--;
            r.changed = 1'b1;
          end
        end else if (m_sum < fast_lim) begin
          if (m_level != frqg_pkg::LEVEL_ULTRA) begin
            m_level++;
            r.changed = 1'b1;
          end
        end
      end
    end
    r.level = m_level;
    r.sum = m_sum[OSUM_W-1:0];
    r.count = m_count[OCOUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame(input int unsigned span);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return FRAME_MAX;
      2, 3, 4: return FRAME_W'($urandom_range(0, FRAME_MAX));
      default: return FRAME_W'($urandom_range(0, span));
    endcase
  endfunction

  // Leaves valid high on return; the next call or a drain decides what follows.
  task automatic send_frame(input logic [FRAME_W-1:0] f);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_us_i <= f;
    do @(posedge clk_i); while (in_stall_o);
    expected_reports.push_back(governor_step(f));
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained;
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input frqg_pkg::cfg_reg_e idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      frqg_pkg::CFG_UPDATE_INTERVAL: m_interval = data[INTERVAL_W-1:0];
      frqg_pkg::CFG_SLOW_FRAME:      m_slow = data[THRESH_W-1:0];
      frqg_pkg::CFG_FAST_FRAME:      m_fast = data[THRESH_W-1:0];
      frqg_pkg::CFG_AUTO_ADJUST:     m_auto = data[0];
      frqg_pkg::CFG_WINDOW_SIZE:     m_wsize = data[WSIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_config(input logic [INTERVAL_W-1:0] interval,
                             input logic [THRESH_W-1:0] slow,
                             input logic [THRESH_W-1:0] fast,
                             input logic auto_on,
                             input logic [WSIZE_W-1:0] wsize);
    write_reg(frqg_pkg::CFG_UPDATE_INTERVAL, CFG_DATA_W'(interval));
    write_reg(frqg_pkg::CFG_SLOW_FRAME, CFG_DATA_W'(slow));
    write_reg(frqg_pkg::CFG_FAST_FRAME, CFG_DATA_W'(fast));
    write_reg(frqg_pkg::CFG_AUTO_ADJUST, CFG_DATA_W'(auto_on));
    write_reg(frqg_pkg::CFG_WINDOW_SIZE, CFG_DATA_W'(wsize));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_report = '{level_o, level_changed_o, evaluated_o, window_sum_o, window_count_o};
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected: expected none, actual level %0d sum %0d",
                 $time, seen_report.level, seen_report.sum);
      end else begin
        want_report = expected_reports.pop_front();
        check_field("level", want_report.level, seen_report.level);
        check_field("level_changed", want_report.changed, seen_report.changed);
        check_field("evaluated", want_report.evaluated, seen_report.evaluated);
        check_field("window_sum", want_report.sum, seen_report.sum);
        check_field("window_count", want_report.count, seen_report.count);
      end
    end
  end

  // Receiver side: a long hold-off when asked, otherwise random stall bursts.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_frame_rate_quality_governor_unit: FAIL");
    $finish;
  end

  // Only the window size is written, so the interval keeps its reset value.
  // A zero-size window stays empty and its zero sum forces a step down,
  // which the low level blocks.
  task automatic test_empty_window;
    write_reg(frqg_pkg::CFG_WINDOW_SIZE, CFG_DATA_W'(0));
    cfg_valid_i <= 1'b0;
    send_frame('0);
    send_frame(FRAME_MAX);
    wait_results_drained;
  endtask

  // One-entry window evaluated on every word: climb to ultra and saturate,
  // hold on both exact thresholds, then step down to low and saturate there.
  task automatic test_level_steps;
    load_config('0, 20'd20000, 20'd10000, 1'b1, 7'd1);
    repeat (4) send_frame(20'd5000);
    send_frame(20'd10000);
    send_frame(20'd20000);
    send_frame(20'd20001);
    send_frame('0);
    send_frame(FRAME_MAX);
    send_frame(FRAME_MAX);
    send_frame(20'd5000);
    wait_results_drained;
  endtask

  task automatic test_auto_off;
    load_config('0, 20'd20000, 20'd10000, 1'b0, 7'd2);
    send_frame('0);
    send_frame(FRAME_MAX);
    wait_results_drained;
  endtask

  // Window size above the ring depth is clamped to the depth.
  task automatic test_oversized_window;
    load_config(24'd10, 20'd33333, 20'd14285, 1'b1, 7'd127);
    send_frame(20'd1);
    send_frame(20'd20);
    wait_results_drained;
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input while words keep being offered, then everything drains.
  task automatic test_receiver_hold;
    load_config(24'd50000, 20'd33333, 20'd14285, 1'b1, 7'd8);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_left = 150;
    repeat (24) send_frame(FRAME_W'($urandom_range(0, 60000)));
    wait_results_drained;
  endtask

  task automatic test_random_phases;
    logic [INTERVAL_W-1:0] interval;
    logic [THRESH_W-1:0]   slow;
    logic [THRESH_W-1:0]   fast;
    logic [WSIZE_W-1:0]    wsize;
    int unsigned           span;
    int unsigned           cap;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 7))
        0:       slow = 20'd1;
        1:       slow = FRAME_MAX;
        default: slow = THRESH_W'($urandom_range(2000, 60000));
      endcase
      // The first phase uses the widest interval so that the elapsed time
      // saturates before it is reached.
      if (p == 0) slow = FRAME_MAX;
      case ($urandom_range(0, 7))
        0:       fast = 20'd1;
        1:       fast = FRAME_MAX;
        default: fast = THRESH_W'($urandom_range(1, slow));
      endcase
      cap = (3 * slow > INTERVAL_MAX) ? INTERVAL_MAX : 3 * slow;
      case ($urandom_range(0, 5))
        0:       interval = '0;
        1:       interval = INTERVAL_MAX;
        default: interval = INTERVAL_W'($urandom_range(1, cap));
      endcase
      if (p == 0) interval = 24'hFFFFFF;
      if (p == 1) interval = '0;
      case ($urandom_range(0, 7))
        0:       wsize = 7'd0;
        1:       wsize = 7'd127;
        2:       wsize = 7'd64;
        3:       wsize = 7'd1;
        default: wsize = WSIZE_W'($urandom_range(2, 63));
      endcase
      load_config(interval, slow, fast, $urandom_range(0, 4) != 0, wsize);
      tx_idle_en = (p != RANDOM_PHASES - 1);
      rx_idle_en = (p != RANDOM_PHASES - 1);
      span = (2 * slow > FRAME_MAX) ? FRAME_MAX : 2 * slow;
      repeat (PHASE_FRAMES) send_frame(pick_frame(span));
      wait_results_drained;
    end
  endtask

  initial begin
    m_interval = frqg_pkg::INTERVAL_RST;
    m_slow = frqg_pkg::SLOW_RST;
    m_fast = frqg_pkg::FAST_RST;
    m_auto = frqg_pkg::AUTO_RST;
    m_wsize = frqg_pkg::WSIZE_RST;
    m_head = 0;
    m_count = 0;
    m_elapsed = 0;
    m_sum = 0;
    m_level = frqg_pkg::LEVEL_LOW;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_empty_window;
    test_level_steps;
    test_auto_off;
    test_oversized_window;
    test_receiver_hold;
    test_random_phases;
    repeat (8) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      errors++;
      $display("%0t: results missing: expected %0d more, actual 0",
               $time, expected_reports.size());
    end
    if (errors == 0) begin
      $display("tb_frame_rate_quality_governor_unit: PASS");
    end else begin
      $display("tb_frame_rate_quality_governor_unit: FAIL");
    end
    $finish;
  end

endmodule

### frame_rate_quality_governor_unit.f
rtl/frqg_pkg.sv
rtl/frame_rate_quality_governor_unit.sv
bench/tb_frame_rate_quality_governor_unit.sv
